>>> rtl/bcls_pkg.sv
// ----------------------------------------------------------------------------
// bcls_pkg
// shared widths, register indexes, request codes, pin levels, event kinds and
// reset values for the button press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bcls_pkg;

    // field widths
    localparam int BTN_W = 2;
    localparam int REG_W = 24;
    localparam int IDX_W = 2;

    // button count, bounded by the button field width
    localparam int NUM_BUTTONS = 4;

    // request codes
    localparam logic REQ_PIN  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // pin levels, active low
    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    // event kinds
    localparam logic EVT_PRESS = 1'b0;
    localparam logic EVT_LONG  = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_REBOOT_HOLD = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT_SLOW = 2'd2;
    localparam logic [IDX_W-1:0] REG_REPEAT_FAST = 2'd3;

    // configuration reset values
    localparam logic [REG_W-1:0] RST_LONG_PRESS  = 24'd32768;
    localparam logic [REG_W-1:0] RST_REBOOT_HOLD = 24'd98304;
    localparam logic [REG_W-1:0] RST_REPEAT_SLOW = 24'd16384;
    localparam logic [REG_W-1:0] RST_REPEAT_FAST = 24'd8192;

endpackage

`default_nettype wire

>>> rtl/button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_press_classifier_top
// classifies active-low buttons into pressed, long-pressed and auto-repeat
// events, and flags a reboot request when all buttons are held long enough
// ----------------------------------------------------------------------------
// Each input item is a pin-change report or one time tick. The item is taken
// into an input register and processed once the result register is free:
// all per-button hold times are computed in parallel lanes, the button state
// and repeat timer are updated, and the results of that item are loaded as a
// button mask into a result register. Results leave one per cycle in ascending
// button order while the output is ready, and an item causes at most four
// results. The input register takes the next item while earlier results still
// wait at the output.
`default_nettype none

module button_press_classifier_top #(
    parameter int TIME_WIDTH  = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration write port
    input  wire                            i_cfg_wr_en,
    input  wire [bcls_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [bcls_pkg::REG_W-1:0]      i_cfg_data,
    // input items
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_req_type,
    input  wire [bcls_pkg::BTN_W-1:0]      i_button,
    input  wire                            i_pin_level,
    // result items
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [bcls_pkg::BTN_W-1:0]     o_which_button,
    output logic                           o_event_kind,
    output logic                           o_reboot_request,
    output logic                           o_last
);

    localparam int NUM_BUTTONS = bcls_pkg::NUM_BUTTONS;
    localparam int CMP_W = (TIME_WIDTH > bcls_pkg::REG_W) ? TIME_WIDTH : bcls_pkg::REG_W;

    // configuration registers
    logic [bcls_pkg::REG_W-1:0] r_long_ticks;
    logic [bcls_pkg::REG_W-1:0] r_reboot_ticks;
    logic [bcls_pkg::REG_W-1:0] r_slow_ticks;
    logic [bcls_pkg::REG_W-1:0] r_fast_ticks;

    // input register
    logic                       r_in_valid;
    logic                       r_req_type;
    logic [bcls_pkg::BTN_W-1:0] r_button;
    logic                       r_pin_level;

    // button and timer state
    logic [TIME_WIDTH-1:0]      r_time;
    logic [TIME_WIDTH-1:0]      r_down [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]     r_held;
    logic [bcls_pkg::REG_W-1:0] r_count;
    logic                       r_armed;

    // result register
    logic [NUM_BUTTONS-1:0]     r_mask;
    logic                       r_kind;
    logic                       r_reboot;

    // next values
    logic [TIME_WIDTH-1:0]      n_time;
    logic [TIME_WIDTH-1:0]      n_down [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]     n_held;
    logic [bcls_pkg::REG_W-1:0] n_count;
    logic                       n_armed;
    logic [NUM_BUTTONS-1:0]     n_mask;
    logic                       n_kind;
    logic                       n_reboot;

    logic                       is_tick;
    logic [TIME_WIDTH-1:0]      time_eval;
    logic [TIME_WIDTH-1:0]      held_for [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]     long_hit;
    logic [NUM_BUTTONS-1:0]     reboot_hit;
    logic [NUM_BUTTONS-1:0]     lane_hit;
    logic [NUM_BUTTONS-1:0]     emit;

    logic [bcls_pkg::BTN_W-1:0] cur_idx;
    logic [NUM_BUTTONS-1:0]     cur_onehot;
    logic [NUM_BUTTONS-1:0]     rest_mask;
    logic                       cur_last;
    logic                       take;
    logic                       bat_free;
    logic                       advance;

    // result selection: lowest pending button first
    always_comb begin
        cur_idx    = '0;
        cur_onehot = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                cur_idx    = bcls_pkg::BTN_W'(i);
                cur_onehot = NUM_BUTTONS'(1) << i;
            end
        end
    end

    assign rest_mask = r_mask & ~cur_onehot;
    assign cur_last  = (rest_mask == '0);

    assign o_out_valid      = (r_mask != '0);
    assign o_which_button   = cur_idx;
    assign o_event_kind     = r_kind;
    assign o_reboot_request = r_reboot & cur_last;
    assign o_last           = cur_last;

    // handshake
    assign take       = o_out_valid & i_out_ready;
    assign bat_free   = !o_out_valid || (take && cur_last);
    assign advance    = r_in_valid && bat_free;
    assign o_in_ready = !r_in_valid || bat_free;

    // per-button hold time lanes
    assign is_tick   = (r_req_type == bcls_pkg::REQ_TICK);
    assign time_eval = is_tick ? r_time + 1'b1 : r_time;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            held_for[i]   = time_eval - r_down[i];
            long_hit[i]   = CMP_W'(held_for[i]) > CMP_W'(r_long_ticks);
            reboot_hit[i] = CMP_W'(held_for[i]) > CMP_W'(r_reboot_ticks);
            lane_hit[i]   = !is_tick &&
                            ({{(32 - bcls_pkg::BTN_W){1'b0}}, r_button} == 32'(i));
        end
    end

    // state update for the item in the input register
    always_comb begin
        n_time   = r_time;
        n_held   = r_held;
        n_count  = r_count;
        n_armed  = r_armed;
        n_mask   = '0;
        n_kind   = bcls_pkg::EVT_PRESS;
        n_reboot = 1'b0;
        emit     = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_down[i] = r_down[i];
        end

        if (is_tick) begin
            n_time = time_eval;
            if (r_armed) begin
                if (r_count <= bcls_pkg::REG_W'(1)) begin
                    // expiry: repeat event for every button held past long press
                    emit     = r_held & long_hit;
                    n_mask   = emit;
                    n_reboot = &(r_held & reboot_hit);
                    if (r_held != '0) begin
                        n_armed = 1'b1;
                        n_count = (emit != '0) ? r_fast_ticks : r_slow_ticks;
                    end else begin
                        n_armed = 1'b0;
                        n_count = '0;
                    end
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
        end else if (r_pin_level == bcls_pkg::PIN_PRESSED) begin
            // press or still down
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (lane_hit[i] && !r_held[i]) begin
                    n_held[i] = 1'b1;
                    n_down[i] = r_time;
                end
            end
            if (lane_hit != '0 && !r_armed) begin
                n_armed = 1'b1;
                n_count = r_slow_ticks;
            end
        end else begin
            // release or still up
            emit   = lane_hit & r_held;
            n_mask = emit;
            n_kind = ((lane_hit & long_hit) != '0) ? bcls_pkg::EVT_LONG : bcls_pkg::EVT_PRESS;
            n_held = r_held & ~lane_hit;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= bcls_pkg::RST_LONG_PRESS;
            r_reboot_ticks <= bcls_pkg::RST_REBOOT_HOLD;
            r_slow_ticks   <= bcls_pkg::RST_REPEAT_SLOW;
            r_fast_ticks   <= bcls_pkg::RST_REPEAT_FAST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bcls_pkg::REG_LONG_PRESS:  r_long_ticks   <= i_cfg_data;
                bcls_pkg::REG_REBOOT_HOLD: r_reboot_ticks <= i_cfg_data;
                bcls_pkg::REG_REPEAT_SLOW: r_slow_ticks   <= i_cfg_data;
                bcls_pkg::REG_REPEAT_FAST: r_fast_ticks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req_type  <= i_req_type;
            r_button    <= i_button;
            r_pin_level <= i_pin_level;
        end
    end

    // button state, timer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_held   <= '0;
            r_count  <= '0;
            r_armed  <= 1'b0;
            r_mask   <= '0;
            r_kind   <= bcls_pkg::EVT_PRESS;
            r_reboot <= 1'b0;
        end else if (advance) begin
            r_time   <= n_time;
            r_held   <= n_held;
            r_count  <= n_count;
            r_armed  <= n_armed;
            r_mask   <= n_mask;
            r_kind   <= n_kind;
            r_reboot <= n_reboot;
        end else if (take) begin
            r_mask <= rest_mask;
        end
    end

    // press timestamps
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_down[i] <= n_down[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bcls_checker.sv
// ----------------------------------------------------------------------------
// bcls_checker
// port-level checks on the result channel of the button press classifier
// ----------------------------------------------------------------------------
`default_nettype none

module bcls_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [bcls_pkg::BTN_W-1:0]  o_which_button,
    input wire                        o_event_kind,
    input wire                        o_reboot_request,
    input wire                        o_last
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item right after reset");

    // stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_which_button)
            && $stable(o_event_kind) && $stable(o_last))
        else $error("stalled result item changed");

    // reboot only flagged on the final result of an expiry
    a_reboot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reboot_request |-> o_last && o_event_kind == bcls_pkg::EVT_PRESS)
        else $error("reboot request on a non-final or long-press item");

    // long press comes from a release, which has a single result
    a_long_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == bcls_pkg::EVT_LONG |-> o_last)
        else $error("long press item not final");

    // a batch continues with a higher button until its final result
    a_batch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid
            && o_which_button > $past(o_which_button))
        else $error("result batch broken or out of order");

endmodule

bind button_press_classifier_top bcls_checker u_bcls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_which_button   (o_which_button),
    .o_event_kind     (o_event_kind),
    .o_reboot_request (o_reboot_request),
    .o_last           (o_last)
);

`default_nettype wire
